// ===== src/tcf_pkg.sv =====
`default_nettype none
package tcf_pkg;

  localparam logic [7:0] T_IAC  = 8'd255;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO     = 8'd1;
  localparam logic [7:0] OPT_TIMING   = 8'd6;
  localparam logic [7:0] OPT_TERMTYPE = 8'd24;
  localparam logic [7:0] SUB_SEND     = 8'd1;

  localparam int SKIP_ECHO_BIT  = 0;
  localparam int SKIP_REPLY_BIT = 1;

  localparam logic CFG_IDX_SKIP = 1'b0;
  localparam logic CFG_IDX_RAW  = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_REPLY = 2'd2,
    ACT_TTYPE = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    PS_DATA   = 5'b00001,
    PS_IAC    = 5'b00010,
    PS_OPT    = 5'b00100,
    PS_SUB    = 5'b01000,
    PS_SUBIAC = 5'b10000
  } parse_state_t;

  typedef struct packed {
    logic [1:0] skip_flags;
    logic       raw_mode;
  } cfg_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
    logic [7:0] reply_cmd;
    logic [7:0] reply_opt;
    logic       echo_remote;
  } result_t;

endpackage
`default_nettype wire

// ===== src/tcf_cfg_regs.sv =====
`default_nettype none
module tcf_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_wdata,
  output tcf_pkg::cfg_t    cfg
);
  import tcf_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_SKIP: cfg_r.skip_flags <= cfg_wdata;
        CFG_IDX_RAW:  cfg_r.raw_mode   <= cfg_wdata[0];
        default:      cfg_r            <= cfg_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/tcf_parser.sv =====
`default_nettype none
module tcf_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic [7:0]  rx_byte,
  input  wire tcf_pkg::cfg_t cfg,
  output tcf_pkg::result_t res
);
  import tcf_pkg::*;

  parse_state_t state_r, state_nxt;
  logic [7:0]   held_cmd_r, held_cmd_nxt;
  logic [7:0]   sub_opt_r, sub_opt_nxt;
  logic [7:0]   sub_first_r, sub_first_nxt;
  logic [1:0]   sub_pos_r, sub_pos_nxt;
  logic         echo_r, echo_nxt;
  logic         skip_echo, skip_reply;

  assign skip_echo  = cfg.skip_flags[SKIP_ECHO_BIT];
  assign skip_reply = cfg.skip_flags[SKIP_REPLY_BIT];

  always_comb begin
    state_nxt     = PS_DATA;
    held_cmd_nxt  = held_cmd_r;
    sub_opt_nxt   = sub_opt_r;
    sub_first_nxt = sub_first_r;
    sub_pos_nxt   = sub_pos_r;
    echo_nxt      = echo_r;
    res           = '0;
    res.action    = ACT_NONE;

    unique case (state_r)
      PS_IAC: begin
        if (rx_byte == T_IAC) begin
          res.action    = ACT_DATA;
          res.data_byte = T_IAC;
        end else if (rx_byte == T_SB) begin
          sub_opt_nxt   = '0;
          sub_first_nxt = '0;
          sub_pos_nxt   = '0;
          state_nxt     = PS_SUB;
        end else if (rx_byte >= T_WILL) begin
          held_cmd_nxt = rx_byte;
          state_nxt    = PS_OPT;
        end
      end
      PS_OPT: begin
        if (held_cmd_r == T_DO) begin
          if (!skip_reply) begin
            res.action    = ACT_REPLY;
            res.reply_opt = rx_byte;
            res.reply_cmd = (rx_byte == OPT_TERMTYPE && cfg.raw_mode) ? T_WILL : T_WONT;
          end
        end else if (held_cmd_r == T_WILL) begin
          if (rx_byte == OPT_ECHO) begin
            if (!skip_echo) echo_nxt = 1'b1;
          end else if (rx_byte != OPT_TIMING) begin
            res.action    = ACT_REPLY;
            res.reply_cmd = T_DONT;
            res.reply_opt = rx_byte;
          end
        end else if (held_cmd_r == T_WONT) begin
          if (rx_byte == OPT_ECHO && !skip_echo) begin
            echo_nxt = 1'b0;
            if (!skip_reply) res.action = ACT_TTYPE;
          end
        end
      end
      PS_SUB, PS_SUBIAC: begin
        if (state_r == PS_SUB && rx_byte == T_IAC) begin
          state_nxt = PS_SUBIAC;
        end else if (state_r == PS_SUB || rx_byte == T_IAC) begin
          // body byte
          state_nxt = PS_SUB;
          if (sub_pos_r == 2'd0) sub_opt_nxt = rx_byte;
          else if (sub_pos_r == 2'd1) sub_first_nxt = rx_byte;
          if (sub_pos_r != 2'd3) sub_pos_nxt = sub_pos_r + 2'd1;
        end else if (rx_byte == T_SE) begin
          if (sub_pos_r >= 2'd2 && sub_opt_r == OPT_TERMTYPE && sub_first_r == SUB_SEND)
            res.action = ACT_TTYPE;
        end
      end
      default: begin
        if (rx_byte == T_IAC) begin
          state_nxt = PS_IAC;
        end else if (rx_byte != 8'd0) begin
          res.action    = ACT_DATA;
          res.data_byte = rx_byte;
        end
      end
    endcase

    res.echo_remote = echo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PS_DATA;
      held_cmd_r  <= '0;
      sub_opt_r   <= '0;
      sub_first_r <= '0;
      sub_pos_r   <= '0;
      echo_r      <= 1'b0;
    end else if (step_en) begin
      state_r     <= state_nxt;
      held_cmd_r  <= held_cmd_nxt;
      sub_opt_r   <= sub_opt_nxt;
      sub_first_r <= sub_first_nxt;
      sub_pos_r   <= sub_pos_nxt;
      echo_r      <= echo_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/telnet_command_filter.sv =====
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   in_rx_byte
// out_      output     out_valid / out_stall out_action, out_data_byte, out_reply_cmd,
//                                            out_reply_opt, out_echo_remote
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// one beat in and one beat out per cycle while out_stall is low; each beat passes
// through the input register, then the parser step into the output register
// synchronous active-low reset clears parse state, config and valid flags
// out_stall holds the output register; the input register then fills and in_stall rises
`default_nettype none
module telnet_command_filter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_action,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_reply_cmd,
  output logic [7:0]      out_reply_opt,
  output logic            out_echo_remote,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_wdata
);
  import tcf_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       out_free, s1_move, s1_load;

  tcf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tcf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_move),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || out_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) s1_byte_r <= in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) out_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.action;
  assign out_data_byte   = out_r.data_byte;
  assign out_reply_cmd   = out_r.reply_cmd;
  assign out_reply_opt   = out_r.reply_opt;
  assign out_echo_remote = out_r.echo_remote;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tcf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 160;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_action;
  logic [7:0] out_data_byte;
  logic [7:0] out_reply_cmd;
  logic [7:0] out_reply_opt;
  logic       out_echo_remote;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  telnet_command_filter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_data_byte   (out_data_byte),
    .out_reply_cmd   (out_reply_cmd),
    .out_reply_opt   (out_reply_opt),
    .out_echo_remote (out_echo_remote),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // parser mirror
  parse_state_t rx_phase   = PS_DATA;
  logic [7:0]   held_cmd   = 8'd0;
  logic [7:0]   sb_opt     = 8'd0;
  logic [7:0]   sb_first   = 8'd0;
  logic [1:0]   sb_count   = 2'd0;
  logic         echo_flag  = 1'b0;
  logic [1:0]   skip_cfg   = 2'd0;
  logic         raw_cfg    = 1'b0;

  result_t expected_beats[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_written = 0;
  int unsigned n_data = 0, n_reply = 0, n_ttype = 0, n_quiet = 0;

  bit          tx_pacing = 1'b1;
  logic        rx_pacing = 1'b1;
  int unsigned hold_id = 0, hold_len = 0;
  int unsigned hold_seen = 0, hold_left = 0, stall_left = 0;

  function automatic void sb_take(input logic [7:0] b);
    if (sb_count == 2'd0) sb_opt = b;
    else if (sb_count == 2'd1) sb_first = b;
    if (sb_count != 2'd3) sb_count = sb_count + 2'd1;
  endfunction

  function automatic result_t filter_step(input logic [7:0] b);
    result_t r;
    r = '0;
    case (rx_phase)
      PS_IAC: begin
        if (b == T_IAC) begin
          r.action = ACT_DATA;
          r.data_byte = 8'hFF;
          rx_phase = PS_DATA;
        end else if (b == T_SB) begin
          sb_opt = 8'd0;
          sb_first = 8'd0;
          sb_count = 2'd0;
          rx_phase = PS_SUB;
        end else if (b >= T_WILL) begin
          held_cmd = b;
          rx_phase = PS_OPT;
        end else begin
          rx_phase = PS_DATA;
        end
      end
      PS_OPT: begin
        rx_phase = PS_DATA;
        if (held_cmd == T_DO) begin
          if (!skip_cfg[SKIP_REPLY_BIT]) begin
            r.action = ACT_REPLY;
            r.reply_opt = b;
            r.reply_cmd = (b == OPT_TERMTYPE && raw_cfg) ? T_WILL : T_WONT;
          end
        end else if (held_cmd == T_WILL) begin
          if (b == OPT_ECHO) begin
            if (!skip_cfg[SKIP_ECHO_BIT]) echo_flag = 1'b1;
          end else if (b != OPT_TIMING) begin
            r.action = ACT_REPLY;
            r.reply_cmd = T_DONT;
            r.reply_opt = b;
          end
        end else if (held_cmd == T_WONT) begin
          if (b == OPT_ECHO && !skip_cfg[SKIP_ECHO_BIT]) begin
            echo_flag = 1'b0;
            if (!skip_cfg[SKIP_REPLY_BIT]) r.action = ACT_TTYPE;
          end
        end
      end
      PS_SUB: begin
        if (b == T_IAC) rx_phase = PS_SUBIAC;
        else sb_take(b);
      end
      PS_SUBIAC: begin
        if (b == T_IAC) begin
          sb_take(b);
          rx_phase = PS_SUB;
        end else begin
          if (b == T_SE && sb_count >= 2'd2 && sb_opt == OPT_TERMTYPE && sb_first == SUB_SEND)
            r.action = ACT_TTYPE;
          rx_phase = PS_DATA;
        end
      end
      default: begin
        rx_phase = PS_DATA;
        if (b == T_IAC) rx_phase = PS_IAC;
        else if (b != 8'd0) begin
          r.action = ACT_DATA;
          r.data_byte = b;
        end
      end
    endcase
    r.echo_remote = echo_flag;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi, lo);
    return v[7:0];
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned r;
    int unsigned gap;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    expected_beats.push_back(filter_step(b));
    bytes_sent++;
    gap = 0;
    if (tx_pacing) begin
      r = $urandom_range(99);
      if (r >= 93) gap = $urandom_range(40, 10);
      else if (r >= 65) gap = $urandom_range(3, 1);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [7:0] cmd, input logic [7:0] opt);
    send_byte(T_IAC);
    send_byte(cmd);
    send_byte(opt);
  endtask

  task automatic send_sub_byte(input logic [7:0] b);
    send_byte(b);
    if (b == T_IAC) send_byte(T_IAC);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IDX_SKIP) skip_cfg = val;
    else raw_cfg = val[0];
  endtask

  task automatic set_config(input logic [1:0] skip, input logic raw);
    drain();
    cfg_beat(CFG_IDX_SKIP, skip);
    cfg_beat(CFG_IDX_RAW, {rand_byte(0, 1) == 8'd1, raw});
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  task automatic send_random_unit();
    int unsigned kind;
    int unsigned r;
    int unsigned n;
    logic [7:0] cmd;
    logic [7:0] opt;
    kind = $urandom_range(99);
    if (kind < 25) begin
      if ($urandom_range(99) < 5) send_byte(8'd0);
      else send_byte(rand_byte(1, 254));
    end else if (kind < 30) begin
      send_byte(T_IAC);
      send_byte(T_IAC);
    end else if (kind < 37) begin
      // anything short of SB after IAC is a two-byte command
      send_byte(T_IAC);
      send_byte(rand_byte(0, 249));
    end else if (kind < 67) begin
      case ($urandom_range(3))
        0: cmd = T_WILL;
        1: cmd = T_WONT;
        2: cmd = T_DO;
        default: cmd = T_DONT;
      endcase
      r = $urandom_range(99);
      if (r < 30) opt = OPT_ECHO;
      else if (r < 40) opt = OPT_TIMING;
      else if (r < 65) opt = OPT_TERMTYPE;
      else if (r < 70) opt = T_IAC;
      else opt = rand_byte(0, 255);
      send_cmd(cmd, opt);
    end else if (kind < 85) begin
      send_byte(T_IAC);
      send_byte(T_SB);
      if ($urandom_range(99) < 60) begin
        send_sub_byte(OPT_TERMTYPE);
        if ($urandom_range(99) < 80) send_sub_byte(SUB_SEND);
        else send_sub_byte(rand_byte(0, 3));
        n = $urandom_range(2);
      end else begin
        n = $urandom_range(4);
      end
      repeat (n) send_sub_byte(rand_byte(0, 255));
      r = $urandom_range(99);
      if (r < 85) begin
        send_byte(T_IAC);
        send_byte(T_SE);
      end else if (r < 95) begin
        send_byte(T_IAC);
        send_byte(rand_byte(0, 239));
      end
    end else begin
      send_byte(rand_byte(0, 255));
    end
  endtask

  task automatic test_data_bytes();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(T_IAC);
    send_byte(T_IAC);
  endtask

  task automatic test_two_byte_commands();
    send_byte(T_IAC);
    send_byte(8'd241);
    send_byte(T_IAC);
    send_byte(T_SE);
  endtask

  task automatic test_option_replies();
    send_cmd(T_DO, OPT_TERMTYPE);
    send_cmd(T_WILL, OPT_ECHO);
    send_cmd(T_WILL, OPT_TIMING);
    send_cmd(T_WILL, 8'd3);
    send_cmd(T_WONT, OPT_ECHO);
    send_cmd(T_DONT, T_IAC);
  endtask

  task automatic test_subnegotiation();
    send_byte(T_IAC);
    send_byte(T_SB);
    send_byte(OPT_TERMTYPE);
    send_byte(SUB_SEND);
    send_byte(T_IAC);
    send_byte(T_SE);
    // escaped body byte, then an abandoned block
    send_byte(T_IAC);
    send_byte(T_SB);
    send_byte(T_IAC);
    send_byte(T_IAC);
    send_byte(T_IAC);
    send_byte(8'd7);
  endtask

  task automatic test_backpressure();
    drain();
    rx_pacing <= 1'b0;
    hold_len <= 150;
    hold_id <= hold_id + 1;
    tx_pacing = 1'b0;
    repeat (40) send_random_unit();
    // sender waits for every outstanding beat
    drain();
    tx_pacing = 1'b1;
    rx_pacing <= 1'b1;
  endtask

  task automatic test_config_sweep();
    int unsigned phase_end;
    logic [2:0] setting;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: setting = 3'b000;
        1: setting = 3'b111;
        2: setting = 3'b011;
        3: setting = 3'b100;
        4: setting = 3'b001;
        default: setting = 3'b110;
      endcase
      set_config(setting[2:1], setting[0]);
      // one phase runs flat out on both sides
      tx_pacing = (i != 2);
      rx_pacing <= (i != 2);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_unit();
    end
    tx_pacing = 1'b1;
  endtask

  always @(posedge clk) begin : drive_out_stall
    int unsigned r;
    r = $urandom_range(99);
    if (hold_id != hold_seen) begin
      hold_seen <= hold_id;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!rx_pacing) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (r < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= (r < 96) ? $urandom_range(2, 0) : $urandom_range(30, 8);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: action %0d", out_action);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        case (want.action)
          ACT_DATA:  n_data++;
          ACT_REPLY: n_reply++;
          ACT_TTYPE: n_ttype++;
          default:   n_quiet++;
        endcase
        if (out_action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_action);
          error_count++;
        end
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte: expected %0d, got %0d", want.data_byte, out_data_byte);
          error_count++;
        end
        if (out_reply_cmd !== want.reply_cmd) begin
          $error("reply_cmd: expected %0d, got %0d", want.reply_cmd, out_reply_cmd);
          error_count++;
        end
        if (out_reply_opt !== want.reply_opt) begin
          $error("reply_opt: expected %0d, got %0d", want.reply_opt, out_reply_opt);
          error_count++;
        end
        if (out_echo_remote !== want.echo_remote) begin
          $error("echo_remote: expected %0d, got %0d", want.echo_remote, out_echo_remote);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_data_bytes();
    test_two_byte_commands();
    test_option_replies();
    test_subnegotiation();
    test_backpressure();
    test_config_sweep();
    drain();
    rx_pacing <= 1'b0;
    repeat (10) @(posedge clk);
    $display("Run: %0d bytes offered under %0d register settings, long output hold included",
             bytes_sent, settings_written);
    $display("Beats checked: %0d data, %0d replies, %0d terminal-type, %0d silent",
             n_data, n_reply, n_ttype, n_quiet);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcf_pkg.sv
src/tcf_cfg_regs.sv
src/tcf_parser.sv
src/telnet_command_filter.sv
dv/tb_top.sv
